>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of the tile binner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define PTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define PTB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/ptb_pkg.sv
// Package with the types, constants and register codes of the particle tile binner.
`default_nettype none

package ptb_pkg;

  // Count store geometry.
  localparam int unsigned MAX_TILES  = 1024;
  localparam int unsigned TILE_BITS  = $clog2(MAX_TILES);
  localparam int unsigned COUNT_BITS = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Result field widths.
  localparam int unsigned SLOT_W = 20;
  localparam int unsigned DEST_W = 30;
  localparam int unsigned PEAK_W = 20;
  localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

  // Serial divider width and the computed tile width before range checks.
  localparam int unsigned DIV_W    = 16;
  localparam int unsigned TXS_W    = 11;
  localparam int unsigned ROWP_W   = TXS_W + DIV_W;
  localparam int unsigned TILE_W   = ROWP_W + 1;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned STRIDE_W = DIV_W + PHASE_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_WIDTH    = 3'd0,
    REG_TILE_HEIGHT   = 3'd1,
    REG_TILES_X       = 3'd2,
    REG_TILE_COUNT    = 3'd3,
    REG_ROW_OFFSET    = 3'd4,
    REG_TILE_CAPACITY = 3'd5,
    REG_PHASE_DIM     = 3'd6
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [DIV_W-1:0]   RST_TILE_WIDTH    = 16'd16;
  localparam logic [DIV_W-1:0]   RST_TILE_HEIGHT   = 16'd16;
  localparam logic [TXS_W-1:0]   RST_TILES_X       = 11'd32;
  localparam logic [TXS_W-1:0]   RST_TILE_COUNT    = 11'd1024;
  localparam logic [DIV_W-1:0]   RST_ROW_OFFSET    = 16'd0;
  localparam logic [DIV_W-1:0]   RST_TILE_CAPACITY = 16'd256;
  localparam logic [PHASE_W-1:0] RST_PHASE_DIM     = 4'd4;

  // Input word.
  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic        first_in_batch;
    logic        last_in_batch;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [TILE_BITS-1:0] tile_index;
    logic [SLOT_W-1:0]    slot;
    logic [DEST_W-1:0]    dest_index;
    logic                 stored;
    logic                 tile_out_of_range;
    logic [PEAK_W-1:0]    overflow_max;
    logic                 batch_done;
  } out_word_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // Write request to the count memory.
  typedef struct packed {
    logic                  we;
    logic [TILE_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] data;
  } cnt_wr_t;

endpackage

`default_nettype wire

>>> rtl/particle_tile_binner.sv
// Top level of the particle tile binner: sequencer, configuration and result register.
// An accepted word takes two passes through the shared serial divider, x then y
// (request, 16 quotient steps, done), then multiply, tile sum, range check, count read,
// count update with the overflow peak, destination and result load. A row below the
// partition skips the y pass and every later step but the result load, and is marked
// out of range. A word with first_in_batch adds a clearing sweep of the count memory
// first. A result word that is not taken holds the next one. Words are taken one at a
// time: in_ready_o is high only while idle. Reset: asynchronous; afterwards a sweep clears
// the count memory while in_ready_o stays low. Configuration writes are taken at any time.
`default_nettype none

module particle_tile_binner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ptb_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ptb_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ptb_pkg::out_word_t                  out_word_o
);
  import ptb_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DIVX,
    ST_DIVY,
    ST_MUL,
    ST_TILE,
    ST_RANGE,
    ST_READ,
    ST_EVAL,
    ST_DEST,
    ST_OUT
  } state_e;

  // Control state.
  state_e               state_q;
  logic [TILE_BITS-1:0] clr_addr_q;
  logic                 out_valid_q;
  div_req_t             div_req_q;
  logic [PEAK_W-1:0]    peak_q;

  // Configuration registers.
  logic [DIV_W-1:0]   tile_w_q;
  logic [DIV_W-1:0]   tile_h_q;
  logic [TXS_W-1:0]   tiles_x_q;
  logic [TXS_W-1:0]   tile_cnt_q;
  logic [DIV_W-1:0]   row_off_q;
  logic [DIV_W-1:0]   cap_q;
  logic [PHASE_W-1:0] phase_q;

  // Datapath registers.
  logic [DIV_W-1:0]      gx_q, gy_q, qx_q, qy_q;
  logic                  last_q;
  logic                  oor_q;
  logic [ROWP_W-1:0]     rowp_q;
  logic [STRIDE_W-1:0]   stride_q;
  logic [TILE_W-1:0]     tile_q;
  logic [COUNT_BITS-1:0] slot_q;
  logic                  stored_q;
  logic [DEST_W-1:0]     dprod_q;
  logic [DEST_W-1:0]     dest_q;
  out_word_t             out_word_q;

  // Internal combinational signals.
  logic                  accept;
  logic                  out_load;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;
  div_req_t              div_req_d;
  logic [DIV_W-1:0]      wdiv, hdiv;
  logic                  row_below;
  logic                  tile_oor;
  logic                  slot_fits;
  logic [PEAK_W:0]       ov_raw;
  logic [PEAK_W-1:0]     ov_sat;
  logic [COUNT_BITS-1:0] rdata;
  cnt_wr_t               cnt_wr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // A tile size of zero divides as one.
  assign wdiv = (tile_w_q == '0) ? DIV_W'(1) : tile_w_q;
  assign hdiv = (tile_h_q == '0) ? DIV_W'(1) : tile_h_q;

  // Range checks and the overflow amount of a full tile.
  assign row_below = (gy_q < row_off_q);
  assign tile_oor  = (tile_q >= TILE_W'(tile_cnt_q)) || (tile_q >= TILE_W'(MAX_TILES));
  assign slot_fits = (32'(slot_q) < 32'(cap_q));
  assign ov_raw    = (PEAK_W+1)'(slot_q) - (PEAK_W+1)'(cap_q) + (PEAK_W+1)'(1);
  assign ov_sat    = ((ov_raw > (PEAK_W+1)'(PEAK_MAX)) || (32'(slot_q) < 32'(cap_q))) ?
                     PEAK_MAX : ov_raw[PEAK_W-1:0];

  // Count memory writes: zeros during a sweep, the incremented count after a read.
  always_comb begin
    cnt_wr = '0;
    if ((state_q == ST_INIT) || (state_q == ST_CLEAR)) begin
      cnt_wr.we   = 1'b1;
      cnt_wr.addr = clr_addr_q;
      cnt_wr.data = '0;
    end else if (state_q == ST_EVAL) begin
      cnt_wr.we   = (slot_q != COUNT_MAX);
      cnt_wr.addr = tile_q[TILE_BITS-1:0];
      cnt_wr.data = slot_q + 1'b1;
    end
  end

  // Divider requests: the x pass once a word is in (after any clearing sweep),
  // the y pass once x is done and the row lies inside the partition.
  always_comb begin
    div_req_d = '0;
    if (accept && !in_word_i.first_in_batch) begin
      div_req_d = '{start: 1'b1, dividend: in_word_i.x_pos[31:16], divisor: wdiv};
    end else if ((state_q == ST_CLEAR) && (clr_addr_q == TILE_BITS'(MAX_TILES - 1))) begin
      div_req_d = '{start: 1'b1, dividend: gx_q, divisor: wdiv};
    end else if ((state_q == ST_DIVX) && div_done && !row_below) begin
      div_req_d = '{start: 1'b1, dividend: gy_q - row_off_q, divisor: hdiv};
    end
  end

  ptb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  ptb_cnt_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (cnt_wr),
    .raddr_i (tile_q[TILE_BITS-1:0]),
    .rdata_o (rdata)
  );

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q   <= RST_TILE_WIDTH;
      tile_h_q   <= RST_TILE_HEIGHT;
      tiles_x_q  <= RST_TILES_X;
      tile_cnt_q <= RST_TILE_COUNT;
      row_off_q  <= RST_ROW_OFFSET;
      cap_q      <= RST_TILE_CAPACITY;
      phase_q    <= RST_PHASE_DIM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TILE_WIDTH:    tile_w_q   <= cfg_wdata_i;
        REG_TILE_HEIGHT:   tile_h_q   <= cfg_wdata_i;
        REG_TILES_X:       tiles_x_q  <= cfg_wdata_i[TXS_W-1:0];
        REG_TILE_COUNT:    tile_cnt_q <= cfg_wdata_i[TXS_W-1:0];
        REG_ROW_OFFSET:    row_off_q  <= cfg_wdata_i;
        REG_TILE_CAPACITY: cap_q      <= cfg_wdata_i;
        REG_PHASE_DIM:     phase_q    <= cfg_wdata_i[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with its registered outputs: divider requests, overflow peak, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      div_req_q   <= '0;
      peak_q      <= '0;
    end else begin
      div_req_q <= div_req_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == TILE_BITS'(MAX_TILES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            clr_addr_q <= '0;
            if (in_word_i.first_in_batch) begin
              peak_q  <= '0;
              state_q <= ST_CLEAR;
            end else begin
              state_q <= ST_DIVX;
            end
          end
        end
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == TILE_BITS'(MAX_TILES - 1)) begin
            state_q <= ST_DIVX;
          end
        end
        ST_DIVX: begin
          if (div_done) begin
            state_q <= row_below ? ST_OUT : ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:   state_q <= ST_TILE;
        ST_TILE:  state_q <= ST_RANGE;
        ST_RANGE: state_q <= tile_oor ? ST_OUT : ST_READ;
        ST_READ:  state_q <= ST_EVAL;
        ST_EVAL: begin
          // A full tile raises the running overflow peak.
          if (!slot_fits && (ov_sat > peak_q)) begin
            peak_q <= ov_sat;
          end
          state_q <= ST_DEST;
        end
        ST_DEST:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, each loaded in the step that produces it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      gx_q   <= in_word_i.x_pos[31:16];
      gy_q   <= in_word_i.y_pos[31:16];
      last_q <= in_word_i.last_in_batch;
      oor_q  <= 1'b0;
    end
    if ((state_q == ST_DIVX) && div_done) begin
      qx_q <= div_quot;
      if (row_below) begin
        oor_q <= 1'b1;
      end
    end
    if ((state_q == ST_DIVY) && div_done) begin
      qy_q <= div_quot;
    end
    if (state_q == ST_MUL) begin
      rowp_q   <= tiles_x_q * qy_q;
      stride_q <= cap_q * phase_q;
    end
    if (state_q == ST_TILE) begin
      tile_q <= TILE_W'(qx_q) + TILE_W'(rowp_q);
    end
    if ((state_q == ST_RANGE) && tile_oor) begin
      oor_q <= 1'b1;
    end
    if (state_q == ST_READ) begin
      slot_q <= rdata;
    end
    if (state_q == ST_EVAL) begin
      stored_q <= slot_fits;
      dprod_q  <= stride_q * tile_q[TILE_BITS-1:0];
    end
    if (state_q == ST_DEST) begin
      dest_q <= stored_q ? (dprod_q + DEST_W'(slot_q)) : '0;
    end
    if (out_load) begin
      out_word_q.overflow_max      <= peak_q;
      out_word_q.batch_done        <= last_q;
      out_word_q.tile_out_of_range <= oor_q;
      if (oor_q) begin
        out_word_q.tile_index <= '0;
        out_word_q.slot       <= '0;
        out_word_q.dest_index <= '0;
        out_word_q.stored     <= 1'b0;
      end else begin
        out_word_q.tile_index <= tile_q[TILE_BITS-1:0];
        out_word_q.slot       <= SLOT_W'(slot_q);
        out_word_q.dest_index <= dest_q;
        out_word_q.stored     <= stored_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

>>> rtl/ptb_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none

module ptb_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptb_pkg::div_req_t      req_i,
  output logic                   done_o,
  output logic [ptb_pkg::DIV_W-1:0] quot_o
);
  import ptb_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dsr_q;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    fits    = (shifted >= {1'b0, dsr_q});
    rem_d   = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    quo_d   = {quo_q[DIV_W-2:0], fits};
  end

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Remainder, quotient and divisor registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/ptb_cnt_ram.sv
// Tile count memory with one write port and one registered read port.
`default_nettype none

module ptb_cnt_ram (
  input  logic                            clk_i,
  input  ptb_pkg::cnt_wr_t                wr_i,
  input  logic [ptb_pkg::TILE_BITS-1:0]   raddr_i,
  output logic [ptb_pkg::COUNT_BITS-1:0]  rdata_o
);
  import ptb_pkg::*;

  logic [COUNT_BITS-1:0] mem_q [MAX_TILES];
  logic [COUNT_BITS-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/ptb_checker.sv
// Port-level checker for the particle tile binner and its bind statement.
`default_nettype none

`include "assert_macros.svh"

module ptb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ptb_pkg::out_word_t out_word_o
);
  import ptb_pkg::*;

  logic oor_word;
  logic no_place;
  logic unstored_word;
  logic no_dest;

  // Shorthands for the result word checks.
  assign oor_word      = out_valid_o && out_word_o.tile_out_of_range;
  assign no_place      = !out_word_o.stored && (out_word_o.tile_index == '0) &&
                         (out_word_o.slot == '0) && (out_word_o.dest_index == '0);
  assign unstored_word = out_valid_o && !out_word_o.stored;
  assign no_dest       = (out_word_o.dest_index == '0);

  // No result word is offered in the cycle after reset is seen.
  `PTB_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !out_valid_o, "result valid during reset")

  // A result word that is not taken stays offered.
  `PTB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")

  // After a word is taken the binner is busy with it.
  `PTB_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")

  // An out-of-range tile carries no placement.
  `PTB_ASSERT(a_oor_zero, oor_word |-> no_place, "out-of-range word has placement")

  // A particle that is not stored has no destination.
  `PTB_ASSERT(a_unstored_dest, unstored_word |-> no_dest, "unstored word has destination")

endmodule

bind particle_tile_binner ptb_checker u_ptb_checker (.*);

`default_nettype wire
